// ----- hw/rtl/wp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Whirlpool package
// S-box, circulant table row and helpers shared by the hash core.
// ----------------------------------------------------------------------------
package wp_pkg;

  localparam int ROUND_COUNT_DEF = 10;
  localparam int WORD_W = 64;

  function automatic logic [3:0] ebox_f(input logic [3:0] x);
    logic [63:0] t;
    t = 64'h1B9CD6F3E874A250;
    return t[(15 - x) * 4 +: 4];
  endfunction

  function automatic logic [3:0] rbox_f(input logic [3:0] x);
    logic [63:0] t;
    t = 64'h7CBDE49F638A2510;
    return t[(15 - x) * 4 +: 4];
  endfunction

  function automatic logic [3:0] einv_f(input logic [3:0] x);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (ebox_f(4'(i)) == x) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] sbox_f(input logic [7:0] x);
    logic [3:0] u1, l1, r;
    u1 = ebox_f(x[7:4]);
    l1 = einv_f(x[3:0]);
    r  = rbox_f(u1 ^ l1);
    return {ebox_f(u1 ^ r), einv_f(l1 ^ r)};
  endfunction

  function automatic logic [7:0] x2_f(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1D) : {v[6:0], 1'b0};
  endfunction

  function automatic logic [63:0] tab0_f(input logic [7:0] x);
    logic [7:0] s, v2, v4, v8;
    s  = sbox_f(x);
    v2 = x2_f(s);
    v4 = x2_f(v2);
    v8 = x2_f(v4);
    return {s, s, v4, s, v8, v4 ^ s, v2, v8 ^ s};
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } wp_state_t;

endpackage : wp_pkg
`default_nettype wire

// ----- hw/rtl/wp_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface wp_stream_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface : wp_stream_if
`default_nettype wire

// ----- hw/rtl/wp_row_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Whirlpool row unit
// One output row of SubBytes, ShiftColumns and MixRows per cycle.
// ----------------------------------------------------------------------------
module wp_row_unit
  import wp_pkg::*;
(
  input  wire logic [7:0][63:0] src,
  input  wire logic [2:0]       row,
  output logic [63:0]           result
);
  always_comb begin
    logic [63:0] a, t;
    logic [2:0]  k;
    result = '0;
    for (int j = 0; j < 8; j++) begin
      k = row - 3'(j);
      a = src[k];
      t = tab0_f(a[56 - 8 * j +: 8]);
      result ^= (j == 0) ? t : ((t >> (8 * j)) | (t << (64 - 8 * j)));
    end
  end
endmodule : wp_row_unit
`default_nettype wire

// ----- hw/rtl/whirlpool_hash_512.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle while the block stays short of full and the
//   word is not final; a word that fills it holds the input through the
//   transfer, 16 row steps per round through the one shared row unit, fold.
// Final item: each pad block goes through pad, rounds and fold; one or two pad
//   blocks, then eight digest transfers at one per cycle at best.
// Reset (rst, synchronous): chaining value, fill and length cleared, idle.
// ----------------------------------------------------------------------------
// Whirlpool 512 hash
// Fills 512-bit blocks from 64-bit words and compresses them iteratively.
// ----------------------------------------------------------------------------
module whirlpool_hash_512
  import wp_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  wp_stream_if.sink   in_ch,
  wp_stream_if.source out_ch
);
  localparam int RW = $clog2(ROUND_COUNT + 1);

  wp_state_t state;
  logic [7:0][63:0] cv, blk, key, st;
  logic [6:0][63:0] ns;
  logic [63:0] spill_word;   // word that completed the block
  logic [3:0]  spill_n;      // its valid byte count
  logic [3:0]  spill_used;   // bytes of it that went into the full block
  logic [5:0]  fill;
  logic [63:0] len;
  logic        final_pend;   // pad after current compression
  logic        len_pend;     // second pad block still needed
  logic        padded;       // compression in progress is the last one
  logic [RW-1:0] rnd;
  logic [3:0]  step;         // 0..7 key rows, 8..15 state rows
  logic [2:0]  oidx;
  logic [63:0] src_row;
  logic [7:0][63:0] src_sel;

  logic [63:0] w_in;
  logic [3:0]  n_in;
  logic        f_in;
  assign w_in = in_ch.payload.message_word;
  assign n_in = (in_ch.payload.valid_bytes > 4'd8) ? 4'd8 : in_ch.payload.valid_bytes;
  assign f_in = in_ch.payload.final_word;

  assign in_ch.ready = (state == ST_IDLE);

  // Share one row unit between key schedule and state rounds.
  assign src_sel = step[3] ? st : key;
  wp_row_unit u_row (.src(src_sel), .row(step[2:0]), .result(src_row));

  function automatic logic [63:0] rc_f(input logic [RW-1:0] r);
    logic [63:0] v;
    for (int j = 0; j < 8; j++) v[56 - 8 * j +: 8] = sbox_f(8'(8 * r + j));
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cv <= '0;
      fill <= '0;
      len <= '0;
      final_pend <= 1'b0;
      len_pend <= 1'b0;
      padded <= 1'b0;
      oidx <= '0;
      rnd <= '0;
      step <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            logic [7:0][63:0] b;
            logic [6:0] pos;
            b = blk;
            pos = {1'b0, fill};
            // Append valid bytes as a plain byte stream.
            for (int i = 0; i < 8; i++) begin
              if (4'(i) < n_in && pos < 7'd64) begin
                b[pos[5:3]][56 - 8 * pos[2:0] +: 8] = w_in[56 - 8 * i +: 8];
                pos = pos + 7'd1;
              end
            end
            blk <= b;
            len <= len + {57'd0, n_in, 3'd0};
            final_pend <= f_in;
            if (pos == 7'd64) begin
              // Block full: the overflow bytes go into the next block.
              fill <= 6'(7'({1'b0, fill} + {3'd0, n_in}) - 7'd64);
              state <= ST_RUN;
              padded <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                key[i] <= cv[i];
                st[i] <= b[i] ^ cv[i];
              end
              rnd <= '0;
              step <= '0;
              // Leftover bytes stored after compression in ST_FOLD.
              spill_word <= w_in;
              spill_n <= n_in;
              spill_used <= 4'(7'd64 - {1'b0, fill});
            end else begin
              fill <= pos[5:0];
              if (f_in) state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          logic [7:0][63:0] b;
          b = blk;
          for (int p = 0; p < 64; p++) begin
            if (len_pend) b[p / 8][56 - 8 * (p % 8) +: 8] = 8'h00;
            else if (p == fill) b[p / 8][56 - 8 * (p % 8) +: 8] = 8'h80;
            else if (p > fill) b[p / 8][56 - 8 * (p % 8) +: 8] = 8'h00;
          end
          if (!len_pend && fill >= 6'd32) begin
            len_pend <= 1'b1;
            padded <= 1'b0;
          end else begin
            b[7] = len;
            len_pend <= 1'b0;
            padded <= 1'b1;
          end
          blk <= b;
          for (int i = 0; i < 8; i++) begin
            key[i] <= cv[i];
            st[i] <= b[i] ^ cv[i];
          end
          rnd <= '0;
          step <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          // Key rows first, then state rows; commit at the end of each half.
          if (!step[3]) begin
            if (step == 4'd7) begin
              for (int i = 0; i < 7; i++) key[i] <= ns[i];
              key[7] <= src_row;
              ns[0] <= '0;
            end else begin
              ns[step[2:0]] <= (step == 4'd0) ? (src_row ^ rc_f(rnd)) : src_row;
            end
          end else begin
            if (step == 4'd15) begin
              for (int i = 0; i < 7; i++) st[i] <= ns[i];
              st[7] <= src_row ^ key[7];
              if (rnd == RW'(ROUND_COUNT - 1)) state <= ST_FOLD;
              rnd <= rnd + RW'(1);
            end else begin
              ns[step[2:0]] <= src_row ^ key[step[2:0]];
            end
          end
          step <= step + 4'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ st[i] ^ blk[i];
          if (padded) begin
            state <= ST_OUT;
            oidx <= '0;
          end else if (len_pend) begin
            state <= ST_PAD;
          end else begin
            // Restore overflow bytes of the word that completed the block.
            logic [7:0][63:0] b;
            logic [3:0] used;
            b = blk;
            used = spill_used;
            for (int i = 0; i < 8; i++) begin
              if (4'(i) + used < spill_n)
                b[0][56 - 8 * i +: 8] = spill_word[56 - 8 * (i + used) +: 8];
            end
            blk <= b;
            state <= final_pend ? ST_PAD : ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              cv <= '0;
              fill <= '0;
              len <= '0;
              final_pend <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.payload.digest_word  = cv[oidx];
  assign out_ch.payload.digest_index = oidx;
  assign out_ch.payload.digest_last  = (oidx == 3'd7);

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_ch.payload.digest_last |=> state == ST_IDLE)
    else $error("no return to idle");
  a_step_rnd: assert property (@(posedge clk) disable iff (rst)
    state == ST_FOLD |-> $past(state) == ST_RUN) else $error("fold without run");
endmodule : whirlpool_hash_512
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whirlpool 512 hash testbench
// Streams messages word by word into the hash core and checks every digest
// word against a bit-exact software Whirlpool computed alongside. Directed
// messages come first (empty message, byte-count extremes, padding that
// spills into a second block), then random messages, most randomly idled.
// ----------------------------------------------------------------------------
module tb
  import wp_pkg::*;
();

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        final_word;
  } msg_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } digest_beat_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 185;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wp_stream_if #(.payload_t(msg_word_t))    in_ch  (clk);
  wp_stream_if #(.payload_t(digest_beat_t)) out_ch (clk);

  whirlpool_hash_512 u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Software Whirlpool: S-box and circulant row built from the mini-boxes
  // --------------------------------------------------------------------------
  logic [7:0]  sbox_tab [256];
  logic [63:0] circ_tab [256];

  // Chaining value, block buffer, byte fill and bit length of the model
  logic [63:0] hash_state [8];
  logic [63:0] block_buf  [8];
  int unsigned byte_fill;
  logic [63:0] msg_bits;

  digest_beat_t digest_fifo [$];

  int fail_count   = 0;
  int digest_count = 0;
  int msg_count    = 0;
  int item_count   = 0;

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1D) : {v[6:0], 1'b0};
  endfunction

  task automatic build_sbox();
    logic [3:0] e_box [16];
    logic [3:0] r_box [16];
    logic [3:0] e_inv [16];
    logic [3:0] hi, lo, rr;
    logic [7:0] s, d2, d4, d8;
    e_box = '{4'h1, 4'hB, 4'h9, 4'hC, 4'hD, 4'h6, 4'hF, 4'h3,
              4'hE, 4'h8, 4'h7, 4'h4, 4'hA, 4'h2, 4'h5, 4'h0};
    r_box = '{4'h7, 4'hC, 4'hB, 4'hD, 4'hE, 4'h4, 4'h9, 4'hF,
              4'h6, 4'h3, 4'h8, 4'hA, 4'h2, 4'h5, 4'h1, 4'h0};
    for (int i = 0; i < 16; i++) e_inv[e_box[i]] = 4'(i);
    for (int i = 0; i < 256; i++) begin
      hi = e_box[i >> 4];
      lo = e_inv[i & 15];
      rr = r_box[hi ^ lo];
      s  = {e_box[hi ^ rr], e_inv[lo ^ rr]};
      d2 = gf_double(s);
      d4 = gf_double(d2);
      d8 = gf_double(d4);
      sbox_tab[i] = s;
      circ_tab[i] = {s, s, d4, s, d8, d4 ^ s, d2, d8 ^ s};
    end
  endtask

  function automatic logic [63:0] mix_row(input logic [63:0] a [8], input int row);
    logic [63:0] acc;
    logic [63:0] t;
    logic [7:0]  b;
    acc = '0;
    for (int j = 0; j < 8; j++) begin
      b   = a[(row + 8 - j) & 7][56 - 8 * j +: 8];
      t   = circ_tab[b];
      acc = acc ^ ((j == 0) ? t : ((t >> (8 * j)) | (t << (64 - 8 * j))));
    end
    return acc;
  endfunction

  task automatic compress_block();
    logic [63:0] kk [8];
    logic [63:0] ss [8];
    logic [63:0] nk [8];
    logic [63:0] rc;
    for (int i = 0; i < 8; i++) begin
      kk[i] = hash_state[i];
      ss[i] = block_buf[i] ^ hash_state[i];
    end
    for (int r = 0; r < ROUND_COUNT_DEF; r++) begin
      for (int i = 0; i < 8; i++) nk[i] = mix_row(kk, i);
      for (int j = 0; j < 8; j++) rc[56 - 8 * j +: 8] = sbox_tab[(8 * r + j) & 255];
      nk[0] = nk[0] ^ rc;
      kk = nk;
      for (int i = 0; i < 8; i++) nk[i] = mix_row(ss, i) ^ kk[i];
      ss = nk;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] ^ ss[i] ^ block_buf[i];
  endtask

  task automatic append_byte(input logic [7:0] b);
    block_buf[byte_fill >> 3][56 - 8 * (byte_fill & 7) +: 8] = b;
    byte_fill++;
    if (byte_fill == 64) begin
      compress_block();
      byte_fill = 0;
    end
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) begin
      hash_state[i] = '0;
      block_buf[i]  = '0;
    end
    byte_fill = 0;
    msg_bits = '0;
  endtask

  // Absorb one accepted word; final word: pad, finish, queue digest if use_model
  task automatic absorb_word(input msg_word_t w, input bit use_model);
    int n;
    n = (w.valid_bytes > 8) ? 8 : int'(w.valid_bytes);
    for (int i = 0; i < n; i++) append_byte(w.message_word[56 - 8 * i +: 8]);
    msg_bits = msg_bits + 64'(n * 8);
    if (!w.final_word) return;
    append_byte(8'h80);
    // Length no longer fits: flush this block and pad a fresh one
    if (byte_fill > 32) while (byte_fill != 0) append_byte(8'h00);
    while (byte_fill < 56) append_byte(8'h00);
    block_buf[7] = msg_bits;
    compress_block();
    if (use_model)
      for (int i = 0; i < 8; i++) digest_fifo.push_back('{hash_state[i], 3'(i), i == 7});
    for (int i = 0; i < 8; i++) hash_state[i] = '0;
    byte_fill = 0;
    msg_bits = '0;
    msg_count++;
  endtask

  // --------------------------------------------------------------------------
  // Directed table; only the empty message carries a typed-in digest
  // --------------------------------------------------------------------------
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        fin;
    bit          typed;
  } stim_row_t;

  localparam int DIR_ROWS = 26;
  stim_row_t dir_table [DIR_ROWS] = '{
    '{64'h0,                   4'd0,  1'b1, 1'b1},  // empty message
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b0},  // one full word of ones
    '{64'h6100_0000_0000_0000, 4'd1,  1'b1, 1'b0},  // single byte
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0},  // oversized count
    '{64'h0123_4567_89AB_CDEF, 4'd3,  1'b0, 1'b0},  // partial word, not final
    '{64'hFEDC_BA98_7654_3210, 4'd8,  1'b0, 1'b0},
    '{64'hAAAA_5555_AAAA_5555, 4'd7,  1'b1, 1'b0},
    // 31 bytes then final: 0x80 lands at byte 31, length still fits
    '{64'h1111_1111_1111_1111, 4'd8,  1'b0, 1'b0},
    '{64'h2222_2222_2222_2222, 4'd8,  1'b0, 1'b0},
    '{64'h3333_3333_3333_3333, 4'd8,  1'b0, 1'b0},
    '{64'h4444_4444_4444_4444, 4'd7,  1'b0, 1'b0},
    '{64'h0,                   4'd0,  1'b1, 1'b0},
    // 33 bytes: padding spills into a second block
    '{64'h5555_5555_5555_5555, 4'd8,  1'b0, 1'b0},
    '{64'h6666_6666_6666_6666, 4'd8,  1'b0, 1'b0},
    '{64'h7777_7777_7777_7777, 4'd8,  1'b0, 1'b0},
    '{64'h8888_8888_8888_8888, 4'd8,  1'b0, 1'b0},
    '{64'h9900_0000_0000_0000, 4'd1,  1'b1, 1'b0},
    // a full 64-byte block, final word empty
    '{64'h0,                   4'd8,  1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0},
    '{64'h0,                   4'd9,  1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0},
    '{64'h0,                   4'd8,  1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0},
    '{64'h0,                   4'd8,  1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0},
    '{64'h0,                   4'd0,  1'b1, 1'b0}
  };

  // Digest of the empty message from the standard test vectors
  logic [63:0] empty_digest [8] = '{
    64'h19FA61D75522A466, 64'h9B44E39C1D2E1726, 64'hC530232130D407F8,
    64'h9AFEE0964997F7A7, 64'h3E83BE698B288FEB, 64'hCF88E3E03C4F0757,
    64'hEA8964E59B63D937, 64'h08B138CC42A66EB3
  };

  // Flag the monitor reads when a transfer is accepted
  bit row_typed = 1'b0;

  // --------------------------------------------------------------------------
  // Driving at the falling edge
  // --------------------------------------------------------------------------
  int src_idle_pct  = 29;
  int sink_idle_pct = 75;

  // Hold valid until the transfer; the next call decides at the following
  // falling edge whether to drop valid for a gap
  task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic f,
                           input bit typed);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.payload = '{w, n, f};
    row_typed     = typed;
    do @(posedge clk); while (!in_ch.ready);
    item_count++;
  endtask

  always @(negedge clk) begin
    if (!rst) out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: model on input transfers, compare on output transfers
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    digest_beat_t got;
    digest_beat_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_word(in_ch.payload, !row_typed);
        if (row_typed && in_ch.payload.final_word)
          for (int i = 0; i < 8; i++) digest_fifo.push_back('{empty_digest[i], 3'(i), i == 7});
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        digest_count++;
        if (digest_fifo.size() == 0) begin
          $error("unexpected digest transfer: word %h index %0d", got.digest_word,
                 got.digest_index);
          fail_count++;
        end else begin
          want = digest_fifo.pop_front();
          if (got.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
            fail_count++;
          end
          if (got.digest_index !== want.digest_index) begin
            $error("digest_index: expected %0d, got %0d", want.digest_index,
                   got.digest_index);
            fail_count++;
          end
          if (got.digest_last !== want.digest_last) begin
            $error("digest_last: expected %0b, got %0b", want.digest_last, got.digest_last);
            fail_count++;
          end
        end
      end
      // Watchdog: count cycles with no transfer on either side
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic random_word(output logic [63:0] w, output logic [3:0] n);
    int pick;
    w    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 3)       n = 4'($urandom_range(15, 9));  // oversized count
    else if (pick < 8)  n = 4'($urandom_range(7));      // partial mid-stream
    else                n = 4'd8;
  endtask

  initial begin
    logic [63:0] w;
    logic [3:0]  n;
    int          len;
    int          phase;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    build_sbox();
    clear_hash();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_word(dir_table[r].word, dir_table[r].nbytes, dir_table[r].fin,
                dir_table[r].typed);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    row_typed   = 1'b0;

    // Random messages; idling swaps between thirds, last third runs flat out
    phase = 0;
    while (item_count < DIR_ROWS + RANDOM_ITEMS) begin
      if (item_count >= DIR_ROWS + 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (item_count >= DIR_ROWS + RANDOM_ITEMS / 3) begin
        src_idle_pct  = 75;
        sink_idle_pct = 29;
        // Hold off once until the core has drained every digest
        if (phase == 0) begin
          phase = 1;
          @(negedge clk);
          in_ch.valid = 1'b0;
          wait (digest_fifo.size() == 0);
        end
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        random_word(w, n);
        send_word(w, n, 1'b0, 1'b0);
      end
      w = {$urandom, $urandom};
      n = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      send_word(w, n, 1'b1, 1'b0);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    wait (digest_fifo.size() == 0);
    repeat (400) @(posedge clk);

    $display("covered %0d input words across %0d messages, %0d digest words checked",
             item_count, msg_count, digest_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : tb
